### hdl/wwa_pkg.sv
package wwa_pkg;

  // Fixed field widths of the sample and result words.
  localparam int unsigned SAMPLE_W      = 24;
  localparam int unsigned TIME_W        = 48;
  localparam int unsigned PERIOD_W      = 32;
  localparam int unsigned COUNT_OUT_W   = 11;
  localparam int unsigned NUM_LANES     = 6;
  localparam int unsigned MAX_COUNT_DEF = 1024;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(80000);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] force_x;
    logic signed [SAMPLE_W-1:0] force_y;
    logic signed [SAMPLE_W-1:0] force_z;
    logic signed [SAMPLE_W-1:0] torque_x;
    logic signed [SAMPLE_W-1:0] torque_y;
    logic signed [SAMPLE_W-1:0] torque_z;
    logic [TIME_W-1:0]          sample_time;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg_force_x;
    logic signed [SAMPLE_W-1:0] avg_force_y;
    logic signed [SAMPLE_W-1:0] avg_force_z;
    logic signed [SAMPLE_W-1:0] avg_torque_x;
    logic signed [SAMPLE_W-1:0] avg_torque_y;
    logic signed [SAMPLE_W-1:0] avg_torque_z;
    logic [TIME_W-1:0]          mid_time;
    logic [COUNT_OUT_W-1:0]     window_count;
  } out_word_t;

  // Commands from the window controller to every lane.
  typedef struct packed {
    logic add;   // accumulate the incoming sample
    logic seed;  // with add: replace the sum instead of adding
    logic load;  // start a division of the sum by the count
    logic step;  // one restoring division step
  } lane_ctrl_t;

endpackage

### hdl/wwa_lane.sv
module wwa_lane #(
  parameter int unsigned MAX_COUNT = wwa_pkg::MAX_COUNT_DEF
) (
  input  logic                                clk_i,
  input  wwa_pkg::lane_ctrl_t                 ctrl_i,
  input  logic signed [wwa_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [$clog2(MAX_COUNT+1)-1:0]      count_i,
  output logic signed [wwa_pkg::SAMPLE_W-1:0] mean_o
);
  import wwa_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);
  localparam int unsigned SUM_W = SAMPLE_W + CNT_W;

  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic [SUM_W-1:0]        quo_q, quo_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic                    neg_q, neg_d;
  logic signed [SUM_W-1:0] sample_ext;
  logic [CNT_W:0]          trial;
  logic [CNT_W:0]          trial_sub;
  logic                    fits;
  logic [SAMPLE_W-1:0]     quo_low;

  assign sample_ext = SUM_W'(sample_i);
  assign trial      = {rem_q, quo_q[SUM_W-1]};
  assign fits       = trial >= {1'b0, count_i};
  assign trial_sub  = trial - {1'b0, count_i};

  // The divider works on the magnitude; the sign is put back on the low bits.
  assign quo_low = quo_q[SAMPLE_W-1:0];
  assign mean_o  = signed'(neg_q ? (~quo_low + 1'b1) : quo_low);

  always_comb begin
    acc_d = acc_q;
    quo_d = quo_q;
    rem_d = rem_q;
    neg_d = neg_q;
    if (ctrl_i.add) begin
      acc_d = ctrl_i.seed ? sample_ext : acc_q + sample_ext;
    end
    if (ctrl_i.load) begin
      neg_d = acc_q[SUM_W-1];
      quo_d = acc_q[SUM_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
      rem_d = '0;
    end else if (ctrl_i.step) begin
      rem_d = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

endmodule

### hdl/wwa_ctrl.sv
module wwa_ctrl #(
  parameter int unsigned MAX_COUNT = wwa_pkg::MAX_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [wwa_pkg::TIME_W-1:0]        sample_time_i,
  input  logic                              cfg_valid_i,
  input  logic [wwa_pkg::PERIOD_W-1:0]      cfg_data_i,
  input  logic                              out_free_i,
  output wwa_pkg::lane_ctrl_t               lane_ctrl_o,
  output logic                              emit_o,
  output logic [$clog2(MAX_COUNT+1)-1:0]    count_o,
  output logic [wwa_pkg::TIME_W-1:0]        mid_time_o
);
  import wwa_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_COUNT + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic                open_q;
  logic                was_open_q;
  logic [TIME_W-1:0]   start_q;
  logic [TIME_W-1:0]   time_q;
  logic [TIME_W-1:0]   diff_q;
  logic [TIME_W-1:0]   mid_q;
  logic [CNT_W-1:0]    count_q;
  logic [STEP_W-1:0]   step_q;
  logic [PERIOD_W-1:0] period_q;

  logic                accept;
  logic                close;
  logic [TIME_W-1:0]   abs_diff;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign abs_diff   = (sample_time_i >= start_q) ? (sample_time_i - start_q)
                                                 : (start_q - sample_time_i);
  assign close      = was_open_q &&
                      ((diff_q >= {{(TIME_W-PERIOD_W){1'b0}}, period_q}) ||
                       (count_q >= CNT_W'(MAX_COUNT)));

  assign lane_ctrl_o.add  = accept;
  assign lane_ctrl_o.seed = !open_q;
  assign lane_ctrl_o.load = (state_q == ST_CHECK) && close;
  assign lane_ctrl_o.step = (state_q == ST_DIV);

  assign emit_o     = (state_q == ST_EMIT) && out_free_i;
  assign count_o    = count_q;
  assign mid_time_o = mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      open_q     <= 1'b0;
      was_open_q <= 1'b0;
      start_q    <= '0;
      time_q     <= '0;
      diff_q     <= '0;
      mid_q      <= '0;
      count_q    <= '0;
      step_q     <= '0;
      period_q   <= PERIOD_RESET;
    end else begin
      if (cfg_valid_i) begin
        period_q <= cfg_data_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            was_open_q <= open_q;
            time_q     <= sample_time_i;
            diff_q     <= abs_diff;
            if (!open_q) begin
              open_q  <= 1'b1;
              start_q <= sample_time_i;
              count_q <= CNT_W'(1);
            end else begin
              count_q <= count_q + CNT_W'(1);
            end
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // Overflow-free midpoint: halves summed, carry from both low bits.
          mid_q <= (start_q >> 1) + (time_q >> 1) +
                   TIME_W'(start_q[0] & time_q[0]);
          if (close) begin
            open_q  <= 1'b0;
            step_q  <= STEP_W'(SUM_W - 1);
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (step_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/wrench_window_averager_unit.sv
// Boxcar averager and decimator for timestamped six-axis force/torque words.
// Input channel (in_valid_i / in_stall_o / in_word_i) carries one sample word.
// The first word opens a window; later words add to six running sums until
// the absolute time since the window start reaches window_period or the
// sample count reaches MAX_COUNT. Then one result word leaves on the output
// channel (out_valid_o / out_stall_i / out_word_o) with the six truncated
// means, the midpoint time and the sample count.
// The single register window_period is written through cfg_valid_i /
// cfg_data_i; cfg_ready_o is always high. Write it only while idle.
// Sequencing: a word that does not close a window passes through the check state
// before the next one is taken. A closing word passes through the check,
// divide and emit states, with the division done by the bit-serial restoring
// divider in each of the six lanes, which run in parallel. Its result word
// is registered when the emit state finds the output register free.
// The finished result sits in an output register, so a new window can start
// while the receiver still stalls; a second result waits in the divider lanes
// until the output register frees up, and input is stalled meanwhile.
// Reset closes any window, drops a pending result and restores window_period
// to 80000.
module wrench_window_averager_unit #(
  parameter int unsigned MAX_COUNT = wwa_pkg::MAX_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  wwa_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output wwa_pkg::out_word_t          out_word_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wwa_pkg::PERIOD_W-1:0] cfg_data_i
);
  import wwa_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);

  lane_ctrl_t                 lane_ctrl;
  logic signed [SAMPLE_W-1:0] samples [NUM_LANES];
  logic signed [SAMPLE_W-1:0] means   [NUM_LANES];
  logic                       emit;
  logic                       out_free;
  logic [CNT_W-1:0]           count;
  logic [TIME_W-1:0]          mid_time;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
  out_word_t                  out_q;
  logic                       out_valid_q;

  // The configuration register always takes a write.
  assign cfg_ready_o = 1'b1;

  assign samples[0] = in_word_i.force_x;
  assign samples[1] = in_word_i.force_y;
  assign samples[2] = in_word_i.force_z;
  assign samples[3] = in_word_i.torque_x;
  assign samples[4] = in_word_i.torque_y;
  assign samples[5] = in_word_i.torque_z;

  wwa_ctrl #(
    .MAX_COUNT (MAX_COUNT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_time_i (in_word_i.sample_time),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_free_i    (out_free),
    .lane_ctrl_o   (lane_ctrl),
    .emit_o        (emit),
    .count_o       (count),
    .mid_time_o    (mid_time)
  );

  // One accumulator and divider per axis; all lanes step in lockstep.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    wwa_lane #(
      .MAX_COUNT (MAX_COUNT)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .sample_i (samples[g]),
      .count_i  (count),
      .mean_o   (means[g])
    );
  end

  // The reported count is the low bits of the internal count.
  assign count_ext = {{COUNT_OUT_W{1'b0}}, count};

  // Merge stage: the lane results are gathered into the output register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.avg_force_x  <= means[0];
      out_q.avg_force_y  <= means[1];
      out_q.avg_force_z  <= means[2];
      out_q.avg_torque_x <= means[3];
      out_q.avg_torque_y <= means[4];
      out_q.avg_torque_z <= means[5];
      out_q.mid_time     <= mid_time;
      out_q.window_count <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
